// File: sv/deq_pkg.sv
// Shared types and constants of the double-ended queue.
package deq_pkg;

	localparam int unsigned DEQ_DEPTH      = 16;
	localparam int unsigned DEQ_DATA_WIDTH = 32;

	typedef enum logic [2:0] {
		KIND_PUSH   = 3'd0,
		KIND_INSERT = 3'd1,
		KIND_POP    = 3'd2,
		KIND_REMOVE = 3'd3,
		KIND_SIZE   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] data_in;
	} req_t;

	typedef struct packed {
		logic [31:0] data_out;
		logic [4:0]  occupancy;
		status_t     status;
	} rsp_t;

endpackage

// File: sv/deq_ram.sv
// Slot store: one write port, one read port with registered read data.
module deq_ram #(
	parameter int unsigned DEPTH      = deq_pkg::DEQ_DEPTH,
	parameter int unsigned DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH,
	localparam int unsigned ADDR_W    = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [ADDR_W-1:0]     waddr,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [ADDR_W-1:0]     raddr,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/double_ended_queue.sv
// Top level of the bounded double-ended queue.
//
// Requests arrive on req (kind, data_in) and are taken at a rising edge with
// start high and busy low. busy stays low: every request is taken in the
// cycle it is offered, so one request per cycle is sustained.
// Each request yields one result word on rsp, marked by done for exactly one
// cycle, in the cycle after the request is taken. The delay is set by the
// registered read port of the slot store, which a pop or remove reads at the
// edge that takes the request.
// A push or insert writes the slot store at the edge that takes it; pointers
// and count move at the same edge, so a following request sees them at once.
// A full queue refuses push and insert (status full), an empty one refuses
// pop and remove (status empty); refused requests change nothing.
// Reset empties the queue: pointers and count clear, done drops. The slot
// store is not cleared; only written slots are ever read.
// The receiver cannot stall: a result not taken in its cycle is lost.
module double_ended_queue #(
	parameter int unsigned DEPTH      = deq_pkg::DEQ_DEPTH,
	parameter int unsigned DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  deq_pkg::req_t req,
	output logic          done,
	output deq_pkg::rsp_t rsp
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

	logic [PTR_W-1:0] top_q, bottom_q;
	logic [CNT_W-1:0] count_q;

	logic             accept;
	logic             full, empty;
	logic [PTR_W-1:0] top_next, top_prev, bottom_next, bottom_prev;

	logic             we, re;
	logic [PTR_W-1:0] waddr, raddr;
	logic [PTR_W-1:0] top_d, bottom_d;
	logic [CNT_W-1:0] count_d;
	deq_pkg::status_t status_d;

	logic [DATA_WIDTH-1:0] rdata;
	logic                  valid_s1;
	logic                  taken_s1;
	logic [CNT_W-1:0]      count_s1;
	deq_pkg::status_t      status_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = count_q == FULL_CNT;
	assign empty  = count_q == '0;

	assign top_next    = (top_q == LAST_SLOT) ? '0 : top_q + 1'b1;
	assign top_prev    = (top_q == '0) ? LAST_SLOT : top_q - 1'b1;
	assign bottom_next = (bottom_q == LAST_SLOT) ? '0 : bottom_q + 1'b1;
	assign bottom_prev = (bottom_q == '0) ? LAST_SLOT : bottom_q - 1'b1;

	always_comb begin
		we       = 1'b0;
		re       = 1'b0;
		waddr    = top_q;
		raddr    = bottom_q;
		top_d    = top_q;
		bottom_d = bottom_q;
		count_d  = count_q;
		status_d = deq_pkg::ST_DONE;
		unique case (req.kind)
			deq_pkg::KIND_PUSH: begin
				if (full) begin
					status_d = deq_pkg::ST_FULL;
				end else begin
					we      = accept;
					waddr   = top_q;
					top_d   = top_next;
					count_d = count_q + 1'b1;
				end
			end
			deq_pkg::KIND_INSERT: begin
				if (full) begin
					status_d = deq_pkg::ST_FULL;
				end else begin
					we       = accept;
					waddr    = bottom_prev;
					bottom_d = bottom_prev;
					count_d  = count_q + 1'b1;
				end
			end
			deq_pkg::KIND_POP: begin
				if (empty) begin
					status_d = deq_pkg::ST_EMPTY;
				end else begin
					re      = accept;
					raddr   = top_prev;
					top_d   = top_prev;
					count_d = count_q - 1'b1;
				end
			end
			deq_pkg::KIND_REMOVE: begin
				if (empty) begin
					status_d = deq_pkg::ST_EMPTY;
				end else begin
					re       = accept;
					raddr    = bottom_q;
					bottom_d = bottom_next;
					count_d  = count_q - 1'b1;
				end
			end
			default: begin
				// size query and unused codes: report only
			end
		endcase
	end

	deq_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (DATA_WIDTH'(req.data_in)),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= '0;
			bottom_q <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				top_q    <= top_d;
				bottom_q <= bottom_d;
				count_q  <= count_d;
			end
		end
	end

	// Hold the result fields beside the read data of the slot store.
	always_ff @(posedge clk) begin
		if (accept) begin
			taken_s1  <= re;
			count_s1  <= count_d;
			status_s1 <= status_d;
		end
	end

	assign done          = valid_s1;
	assign rsp.data_out  = taken_s1 ? 32'(rdata) : '0;
	assign rsp.occupancy = 5'(count_s1);
	assign rsp.status    = status_s1;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("stored count exceeds depth");

	a_ring_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		((PTR_W + 1)'(bottom_q) + (PTR_W + 1)'(count_q) >= (PTR_W + 1)'(DEPTH))
			? (top_q == PTR_W'((PTR_W + 1)'(bottom_q) + (PTR_W + 1)'(count_q)
				- (PTR_W + 1)'(DEPTH)))
			: (top_q == PTR_W'((PTR_W + 1)'(bottom_q) + (PTR_W + 1)'(count_q))))
		else $error("top, bottom and count disagree");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("request taken without a result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without a request");

	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == deq_pkg::ST_FULL || rsp.status == deq_pkg::ST_EMPTY))
			|-> (rsp.data_out == '0 && $stable(count_q)))
		else $error("refused request moved state or returned a word");
`endif

endmodule

// File: test/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench of the double-ended queue: directed edge cases, then biased random traffic.
module tb_double_ended_queue;

	// highest code the kind field can carry; codes above KIND_SIZE are unused
	localparam logic [2:0] KIND_TOP_CODE = 3'd7;

	logic          clk    = 1'b0;
	logic          arst_n = 1'b0;
	logic          start  = 1'b0;
	logic          busy;
	deq_pkg::req_t req    = '0;
	logic          done;
	deq_pkg::rsp_t rsp;

	logic [deq_pkg::DEQ_DATA_WIDTH-1:0] shadow_slot [deq_pkg::DEQ_DEPTH];
	int unsigned                        shadow_top;
	int unsigned                        shadow_bottom;
	int unsigned                        shadow_count;
	deq_pkg::rsp_t                      pending_rsp [$];
	int                                 fail_count = 0;
	bit                                 gaps_on    = 1'b1;

	double_ended_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial forever #6 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Apply one request to the shadow deque and return the result it yields.
	function automatic deq_pkg::rsp_t deque_apply(deq_pkg::req_t word);
		deq_pkg::rsp_t r;
		r.data_out = '0;
		r.status   = deq_pkg::ST_DONE;
		case (word.kind)
		deq_pkg::KIND_PUSH: begin
			if (shadow_count >= deq_pkg::DEQ_DEPTH) begin
				r.status = deq_pkg::ST_FULL;
			end else begin
				shadow_slot[shadow_top] = word.data_in;
				shadow_top = (shadow_top + 1) % deq_pkg::DEQ_DEPTH;
				shadow_count++;
			end
		end
		deq_pkg::KIND_INSERT: begin
			if (shadow_count >= deq_pkg::DEQ_DEPTH) begin
				r.status = deq_pkg::ST_FULL;
			end else begin
				shadow_bottom = (shadow_bottom + deq_pkg::DEQ_DEPTH - 1) % deq_pkg::DEQ_DEPTH;
				shadow_slot[shadow_bottom] = word.data_in;
				shadow_count++;
			end
		end
		deq_pkg::KIND_POP: begin
			if (shadow_count == 0) begin
				r.status = deq_pkg::ST_EMPTY;
			end else begin
				shadow_top = (shadow_top + deq_pkg::DEQ_DEPTH - 1) % deq_pkg::DEQ_DEPTH;
				r.data_out = shadow_slot[shadow_top];
				shadow_count--;
			end
		end
		deq_pkg::KIND_REMOVE: begin
			if (shadow_count == 0) begin
				r.status = deq_pkg::ST_EMPTY;
			end else begin
				r.data_out = shadow_slot[shadow_bottom];
				shadow_bottom = (shadow_bottom + 1) % deq_pkg::DEQ_DEPTH;
				shadow_count--;
			end
		end
		default: ;
		endcase
		r.occupancy = 5'(shadow_count);
		return r;
	endfunction

	// Offer one word, hold it until taken, then maybe drop start and idle.
	task automatic send_word(logic [2:0] k, logic [31:0] d);
		deq_pkg::req_t word;
		bit            taken;
		word.kind    = k;
		word.data_in = d;
		start <= 1'b1;
		req   <= word;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		pending_rsp.push_back(deque_apply(word));
		// idle each following cycle with a fixed chance
		if (gaps_on) begin
			while ($urandom_range(0, 99) < 36) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// Sample mid-cycle: done and rsp are stable between rising edges.
	always @(negedge clk) begin
		deq_pkg::rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				if (fail_count < 10)
					$display("%0t: unexpected result %h", $time, rsp);
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.data_out !== want.data_out || rsp.occupancy !== want.occupancy ||
						rsp.status !== want.status) begin
					if (fail_count < 10)
						$display("%0t: mismatch data_out %h/%h occupancy %0d/%0d status %0d/%0d",
							$time, want.data_out, rsp.data_out, want.occupancy,
							rsp.occupancy, want.status, rsp.status);
					fail_count++;
				end
			end
		end
	end

	// Pop and remove on an empty queue, size query and the unused codes.
	task automatic test_empty_refusals();
		send_word(deq_pkg::KIND_POP, $urandom);
		send_word(deq_pkg::KIND_REMOVE, $urandom);
		for (int k = deq_pkg::KIND_SIZE; k <= KIND_TOP_CODE; k++)
			send_word(3'(k), $urandom);
	endtask

	// Fill from both ends with extreme words, refuse both adds, take from both ends.
	task automatic test_full_refusals();
		logic [31:0] d;
		for (int i = 0; i < deq_pkg::DEQ_DEPTH; i++) begin
			d = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
			send_word(i[0] ? deq_pkg::KIND_INSERT : deq_pkg::KIND_PUSH, d);
		end
		send_word(deq_pkg::KIND_PUSH, '1);
		send_word(deq_pkg::KIND_INSERT, '0);
		send_word(deq_pkg::KIND_POP, $urandom);
		send_word(deq_pkg::KIND_REMOVE, $urandom);
	endtask

	// Bursts leaning towards filling, draining or neither, so both limits are hit often.
	task automatic test_random_traffic();
		int          add_pct;
		int          r;
		logic [2:0]  k;
		logic [31:0] d;
		for (int b = 0; b < 32; b++) begin
			case (b % 4)
			0: add_pct = 80;
			2: add_pct = 20;
			default: add_pct = 50;
			endcase
			// one long stretch with back-to-back words
			gaps_on = (b < 12 || b > 15);
			for (int i = 0; i < 32; i++) begin
				r = $urandom_range(0, 99);
				if (r < 6)
					k = 3'($urandom_range(deq_pkg::KIND_SIZE, KIND_TOP_CODE));
				else if ($urandom_range(0, 99) < add_pct)
					k = $urandom_range(0, 1) ? deq_pkg::KIND_INSERT : deq_pkg::KIND_PUSH;
				else
					k = $urandom_range(0, 1) ? deq_pkg::KIND_REMOVE : deq_pkg::KIND_POP;
				r = $urandom_range(0, 19);
				d = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
				send_word(k, d);
			end
		end
	endtask

	initial begin
		shadow_top    = 0;
		shadow_bottom = 0;
		shadow_count  = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_refusals();
		test_full_refusals();
		test_random_traffic();
		start <= 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending_rsp.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
sv/deq_pkg.sv
sv/deq_ram.sv
sv/double_ended_queue.sv
test/tb_double_ended_queue.sv
